// ===== rtl/lzf_pkg.sv =====
// Shared constants for the zero-delay-feedback ladder lowpass.
package lzf_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF  = 32;
  localparam int TAN_DEPTH_DEF   = 1024;

  localparam int SR_W     = 18;
  localparam int RES_W    = 16;
  localparam int CUT_W    = 17;
  localparam int CFG_IDX_W = 8;
  localparam int GF       = 30;
  localparam int DF       = 28;
  localparam int RES_FRAC = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE   = 8'd1;

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  // 0.49 in Q0.32
  localparam logic [63:0] PHASE_CLAMP = (64'd49 << 32) / 64'd100;

  // divider widths: remainder and divisor
  localparam int DIV_RW = 34;
  localparam int DIV_DW = 33;

endpackage

// ===== rtl/lzf_front.sv =====
// Input item queue: two entries between the ports and the arithmetic core.
module lzf_front import lzf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [CUT_W-1:0]       cutoff_i,
  output logic                          valid_o,
  input  logic                          take_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic        [CUT_W-1:0]       cutoff_o
);

  logic signed [SAMPLE_BITS-1:0] smp_q [2];
  logic        [CUT_W-1:0]       cut_q [2];
  logic                          wptr_q, rptr_q;
  logic [1:0]                    cnt_q;
  logic                          enq, deq;

  assign full_o   = (cnt_q == 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign enq      = push_i && !full_o;
  assign deq      = take_i && valid_o;
  assign sample_o = smp_q[rptr_q];
  assign cutoff_o = cut_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (enq) begin
      smp_q[wptr_q] <= sample_i;
      cut_q[wptr_q] <= cutoff_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (enq) wptr_q <= ~wptr_q;
      if (deq) rptr_q <= ~rptr_q;
      if (enq && !deq)      cnt_q <= cnt_q + 2'd1;
      else if (!enq && deq) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== rtl/lzf_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by phase and feedback.
module lzf_div import lzf_pkg::*; #(
  parameter int QW = 32,
  parameter int CW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_RW-1:0] rem0_i,
  input  logic [QW-1:0]     low_i,
  input  logic [DIV_DW-1:0] div_i,
  input  logic [CW-1:0]     nbits_i,
  output logic              done_o,
  output logic [QW-1:0]     quot_o
);

  logic [DIV_RW-1:0] rem_q, trial;
  logic [QW-1:0]     low_q, quot_q;
  logic [DIV_DW-1:0] div_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic              fits;

  assign trial  = {rem_q[DIV_RW-2:0], low_q[QW-1]};
  assign fits   = trial >= DIV_RW'(div_q);
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= rem0_i;
        low_q  <= low_i;
        div_q  <= div_i;
        cnt_q  <= nbits_i;
        quot_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? trial - DIV_RW'(div_q) : trial;
        quot_q <= {quot_q[QW-2:0], fits};
        low_q  <= {low_q[QW-2:0], 1'b0};
        cnt_q  <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lzf_core.sv =====
// Back end: prewarp table, shared multiplier, phase and feedback divides and four ladder stages.
module lzf_core import lzf_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int STATE_BITS      = STATE_BITS_DEF,
  parameter int TAN_TABLE_DEPTH = TAN_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_take_o,
  input  logic signed [SAMPLE_BITS-1:0] item_sample_i,
  input  logic        [CUT_W-1:0]       item_cutoff_i,
  input  logic        [SR_W-1:0]        sr_i,
  input  logic        [RES_W-1:0]       res_i,
  output logic                          res_valid_o,
  input  logic                          res_pop_i,
  output logic signed [SAMPLE_BITS-1:0] res_data_o
);

  localparam int SB = STATE_BITS;
  localparam int XB = SAMPLE_BITS;
  localparam int D  = TAN_TABLE_DEPTH;
  localparam int GW = GF + 1;
  localparam int AW = $clog2(D + 1);
  localparam int QW = (SB > 32) ? SB : 32;
  localparam int CW = $clog2(QW + 1);
  localparam int XD = (SB - 4) - (XB - 2);
  localparam int XL = (XD > 0) ? XD : 0;
  localparam int XR = (XD < 0) ? -XD : 0;
  localparam int YL = (XR > 0) ? XR : 0;
  localparam int YR = XL;

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [63:0] XMAX = (64'sd1 <<< (XB - 1)) - 64'sd1;
  localparam logic signed [63:0] XMIN = -XMAX - 64'sd1;
  localparam logic signed [63:0] RSLIM = 64'sd1 <<< 62;
  localparam logic [63:0]        I64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SB-1:0]      QHALF = SB'(1) << (SB - 1);

  typedef logic [GW-1:0] gtab_t [D+1];

  // long division for table build, divisor below 2^63
  function automatic logic [63:0] cdiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic gtab_t fill_gtab();
    gtab_t t;
    logic [63:0] th, th2, ts, tc, den, g;
    logic signed [63:0] s, c;
    for (int i = 0; i <= D; i++) begin
      th  = cdiv(64'd3373259426 * 64'(i), 64'(2 * D));
      th2 = (th * th) >> 30;
      ts  = th;
      tc  = 64'd1 << 30;
      s   = $signed(th);
      c   = $signed(tc);
      for (int n = 1; n <= 8; n++) begin
        ts = cdiv((ts * th2) >> 30, 64'((2 * n) * (2 * n + 1)));
        tc = cdiv((tc * th2) >> 30, 64'((2 * n - 1) * (2 * n)));
        if (n[0]) begin
          s = s - $signed(ts);
          c = c - $signed(tc);
        end else begin
          s = s + $signed(ts);
          c = c + $signed(tc);
        end
      end
      if (s < 0) s = 0;
      if (c < 0) c = 0;
      den = $unsigned(s) + $unsigned(c);
      g   = (den != 0) ? cdiv($unsigned(s) << 30, den) : 64'd0;
      if (g > (64'd1 << 30)) g = 64'd1 << 30;
      t[i] = GW'(g);
    end
    return t;
  endfunction

  localparam gtab_t GTAB = fill_gtab();

  localparam logic [4:0] S_IDLE = 5'd0,  S_PH   = 5'd1,  S_PHW  = 5'd2,  S_IDX  = 5'd3,
                         S_RDA  = 5'd4,  S_RDB  = 5'd5,  S_INT  = 5'd6,  S_G2   = 5'd7,
                         S_G3   = 5'd8,  S_G4   = 5'd9,  S_DEN  = 5'd10, S_SUM  = 5'd11,
                         S_SACC = 5'd12, S_RS   = 5'd13, S_NUM  = 5'd14, S_DIVW = 5'd15,
                         S_STG  = 5'd16, S_UPD  = 5'd17, S_OUT  = 5'd18, S_MLO  = 5'd19,
                         S_MHI  = 5'd20, S_MFIN = 5'd21;

  logic [4:0]             state_q, ret_q;
  logic [1:0]             k_q;
  logic signed [SB-1:0]   st_q [4];
  logic signed [XB-1:0]   x_q;
  logic [CUT_W-1:0]       fc_q;
  logic [31:0]            ph_q, frac_q;
  logic [AW-1:0]          idx_q, rom_addr;
  logic [GW-1:0]          rom_q, ga_q, g_q, g2_q, g3_q, g4_q;
  logic [DIV_DW-1:0]      den_q;
  logic signed [63:0]     s_q, lp_q;
  logic                   neg_q;
  logic signed [63:0]     ms_a_q, ms_r_q;
  logic [31:0]            ms_b_q;
  logic                   ms_c13_q;
  logic [63:0]            plo_q, thi_q;
  logic                   out_valid_q;
  logic signed [XB-1:0]   out_q;
  logic                   out_load;

  // multiply-shift helper
  logic        ms_neg;
  logic [63:0] ms_mag, ms_hichk;
  logic [64:0] ms_sum;
  logic [63:0] ms_res;

  assign ms_neg   = ms_a_q[63];
  assign ms_mag   = ms_neg ? 64'(-ms_a_q) : 64'(ms_a_q);
  assign ms_hichk = ms_c13_q ? (thi_q >> (31 + RES_FRAC)) : (thi_q >> (31 + GF));
  assign ms_sum   = ms_c13_q ?
                    (({1'b0, thi_q} << (32 - RES_FRAC)) + 65'(plo_q >> RES_FRAC)) :
                    (({1'b0, thi_q} << (32 - GF)) + 65'(plo_q >> GF));
  assign ms_res   = ((ms_hichk != 64'd0) || (ms_sum > 65'(I64MAX))) ? I64MAX : ms_sum[63:0];

  // phase and table position
  logic [63:0] pos;
  logic [63:0] idx_full;
  assign pos      = 64'(ph_q) * 64'(2 * D);
  assign idx_full = pos >> 32;

  // interpolation
  logic [GW-1:0] tb;
  logic [63:0]   ip;
  assign tb = (rom_q < ga_q) ? ga_q : rom_q;
  assign ip = 64'(tb - ga_q) * 64'(frac_q);

  // feedback numerator and divider setup
  logic signed [63:0] xs, rsc, num;
  logic [63:0]        num_mag;
  logic [91:0]        n_w, r0_w;
  logic               ovf;
  assign xs      = (64'(x_q) <<< XL) >>> XR;
  assign rsc     = (ms_r_q > RSLIM) ? RSLIM : ((ms_r_q < -RSLIM) ? -RSLIM : ms_r_q);
  assign num     = xs - rsc;
  assign num_mag = num[63] ? 64'(-num) : 64'(num);
  assign n_w     = {num_mag, 28'd0};
  assign r0_w    = n_w >> SB;
  assign ovf     = r0_w >= 92'(den_q);

  logic               div_start, div_done;
  logic [DIV_RW-1:0]  div_rem0;
  logic [QW-1:0]      div_low, div_quot;
  logic [DIV_DW-1:0]  div_dv;
  logic [CW-1:0]      div_nbits;
  logic               fc_over;

  assign fc_over = (64'(fc_q) * 64'd100) > (64'(sr_i) * 64'd49);

  always_comb begin
    div_start = 1'b0;
    div_rem0  = DIV_RW'(fc_q);
    div_low   = '0;
    div_dv    = DIV_DW'(sr_i);
    div_nbits = CW'(32);
    if (state_q == S_PH) begin
      div_start = (sr_i != '0) && !fc_over;
    end else if (state_q == S_NUM) begin
      div_start = !ovf;
      div_rem0  = DIV_RW'(r0_w);
      div_low   = QW'(n_w[SB-1:0]) << (QW - SB);
      div_dv    = den_q;
      div_nbits = CW'(SB);
    end
  end

  lzf_div #(.QW(QW), .CW(CW)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .rem0_i  (div_rem0),
    .low_i   (div_low),
    .div_i   (div_dv),
    .nbits_i (div_nbits),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // quotient to saturated feedback input
  logic [SB-1:0]      q;
  logic signed [63:0] u_val;
  assign q = div_quot[SB-1:0];
  always_comb begin
    if (neg_q) u_val = (q > QHALF) ? SMIN : -64'(q);
    else       u_val = (q >= QHALF) ? SMAX : 64'(q);
  end

  // stage update
  logic signed [63:0] st_k, lp_new, st_new, st_sat;
  assign st_k   = 64'(st_q[k_q]);
  assign lp_new = ms_r_q + st_k;
  assign st_new = lp_new + ms_r_q;
  assign st_sat = (st_new > SMAX) ? SMAX : ((st_new < SMIN) ? SMIN : st_new);

  // output conversion
  logic signed [63:0] y64, ysat;
  assign y64  = (lp_q <<< YL) >>> YR;
  assign ysat = (y64 > XMAX) ? XMAX : ((y64 < XMIN) ? XMIN : y64);

  assign rom_addr = (state_q == S_RDB) ? AW'(idx_q + 1'b1) : idx_q;
  always_ff @(posedge clk_i) begin
    rom_q <= GTAB[rom_addr];
  end

  assign item_take_o = (state_q == S_IDLE) && item_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) st_q[i] <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (res_pop_i && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            x_q     <= item_sample_i;
            fc_q    <= item_cutoff_i;
            state_q <= S_PH;
          end
        end
        S_PH: begin
          if (sr_i == '0) begin
            g_q     <= '0;
            state_q <= S_G2;
          end else if (fc_over) begin
            ph_q    <= PHASE_CLAMP[31:0];
            state_q <= S_IDX;
          end else begin
            state_q <= S_PHW;
          end
        end
        S_PHW: begin
          if (div_done) begin
            ph_q    <= div_quot[31:0];
            state_q <= S_IDX;
          end
        end
        S_IDX: begin
          idx_q   <= (idx_full >= 64'(D)) ? AW'(D - 1) : AW'(idx_full);
          frac_q  <= pos[31:0];
          state_q <= S_RDA;
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          ga_q    <= rom_q;
          state_q <= S_INT;
        end
        S_INT: begin
          g_q     <= ga_q + GW'(ip >> 32);
          state_q <= S_G2;
        end
        S_G2: begin
          g2_q    <= GW'((64'(g_q) * 64'(g_q)) >> GF);
          state_q <= S_G3;
        end
        S_G3: begin
          g3_q    <= GW'((64'(g2_q) * 64'(g_q)) >> GF);
          state_q <= S_G4;
        end
        S_G4: begin
          g4_q    <= GW'((64'(g3_q) * 64'(g_q)) >> GF);
          state_q <= S_DEN;
        end
        S_DEN: begin
          den_q   <= DIV_DW'((64'd1 << DF) +
                     ((64'(g4_q) * 64'(res_i)) >> (GF + RES_FRAC - DF)));
          s_q     <= '0;
          k_q     <= 2'd0;
          state_q <= S_SUM;
        end
        S_SUM: begin
          ms_a_q   <= st_k;
          ms_b_q   <= (k_q == 2'd0) ? 32'(g3_q) : ((k_q == 2'd1) ? 32'(g2_q) : 32'(g_q));
          ms_c13_q <= 1'b0;
          ret_q    <= S_SACC;
          state_q  <= S_MLO;
        end
        S_SACC: begin
          if (k_q == 2'd2) begin
            s_q     <= s_q + ms_r_q + 64'(st_q[3]);
            state_q <= S_RS;
          end else begin
            s_q     <= s_q + ms_r_q;
            k_q     <= k_q + 2'd1;
            state_q <= S_SUM;
          end
        end
        S_RS: begin
          ms_a_q   <= s_q;
          ms_b_q   <= 32'(res_i);
          ms_c13_q <= 1'b1;
          ret_q    <= S_NUM;
          state_q  <= S_MLO;
        end
        S_NUM: begin
          neg_q <= num[63];
          k_q   <= 2'd0;
          if (ovf) begin
            lp_q    <= num[63] ? SMIN : SMAX;
            state_q <= S_STG;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            lp_q    <= u_val;
            state_q <= S_STG;
          end
        end
        S_STG: begin
          ms_a_q   <= lp_q - st_k;
          ms_b_q   <= 32'(g_q);
          ms_c13_q <= 1'b0;
          ret_q    <= S_UPD;
          state_q  <= S_MLO;
        end
        S_UPD: begin
          lp_q      <= lp_new;
          st_q[k_q] <= SB'(st_sat);
          if (k_q == 2'd3) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_STG;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_q   <= XB'(ysat);
            state_q <= S_IDLE;
          end
        end
        S_MLO: begin
          plo_q   <= 64'(ms_mag[31:0]) * 64'(ms_b_q);
          state_q <= S_MHI;
        end
        S_MHI: begin
          thi_q   <= 64'(ms_mag[63:32]) * 64'(ms_b_q);
          state_q <= S_MFIN;
        end
        S_MFIN: begin
          ms_r_q  <= ms_neg ? -$signed(ms_res) : $signed(ms_res);
          state_q <= ret_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ladder_lowpass_zdf.sv =====
// Each item takes the phase through a serial divide unless the cutoff is clamped or the sample
// rate is zero, and the feedback through a second serial divide unless its quotient overflows.
// The core takes the next item only from idle, and a result still waiting in the output
// register holds it in its last step.
// Reset: integrator states clear to zero, sample rate 48000, resonance zero, queues empty.
// A two-entry input queue and a one-entry result register decouple the two sides.
module ladder_lowpass_zdf import lzf_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int STATE_BITS      = STATE_BITS_DEF,
  parameter int TAN_TABLE_DEPTH = TAN_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic        [CUT_W-1:0]       cutoff_hz_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] filtered_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [SR_W-1:0]        cfg_data_i
);

  logic [SR_W-1:0]  sr_q;
  logic [RES_W-1:0] res_q;
  logic             q_valid, q_take, r_valid;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic        [CUT_W-1:0]       q_cutoff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q  <= SR_RESET;
      res_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE: sr_q  <= cfg_data_i;
        CFG_RESONANCE:   res_q <= cfg_data_i[RES_W-1:0];
        default: ;
      endcase
    end
  end

  lzf_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .push_i   (push),
    .full_o   (full),
    .sample_i (sample_in_i),
    .cutoff_i (cutoff_hz_i),
    .valid_o  (q_valid),
    .take_i   (q_take),
    .sample_o (q_sample),
    .cutoff_o (q_cutoff)
  );

  lzf_core #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .STATE_BITS      (STATE_BITS),
    .TAN_TABLE_DEPTH (TAN_TABLE_DEPTH)
  ) u_core (
    .clk_i, .rst_ni,
    .item_valid_i  (q_valid),
    .item_take_o   (q_take),
    .item_sample_i (q_sample),
    .item_cutoff_i (q_cutoff),
    .sr_i          (sr_q),
    .res_i         (res_q),
    .res_valid_o   (r_valid),
    .res_pop_i     (pop),
    .res_data_o    (filtered_out_o)
  );

  assign empty = !r_valid;

endmodule
